// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Boolean condition that must never be seen.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_AT(label, !(cond), msg)

`endif

// ----- hdl/pcm_pkg.sv -----
`timescale 1ns / 1ps

package pcm_pkg;

  localparam int unsigned Cores     = 16;
  localparam int unsigned RingDepth = 8;
  localparam int unsigned CoreW     = $clog2(Cores);
  localparam int unsigned SlotW     = $clog2(RingDepth);
  localparam int unsigned PtrW      = $clog2(2 * RingDepth);
  localparam int unsigned EntryAw   = CoreW + SlotW;
  localparam int unsigned Entries   = Cores * RingDepth;
  localparam int unsigned PendW     = 4;

  localparam logic [7:0] CmdCounted    = 8'd1;
  localparam logic [7:0] CmdInvalidate = 8'd2;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [63:0] arg;
  } entry_t;

  typedef struct packed {
    logic [31:0]     sc;
    logic [31:0]     wc;
    logic [PtrW-1:0] done;
    logic [PtrW-1:0] tail;
  } core_state_t;

  typedef struct packed {
    logic            pad;
    logic [PendW-1:0] pending;
    logic [31:0]     shootdown_count;
    logic [31:0]     work_count;
    logic [63:0]     invalidate_address;
    logic            invalidate_valid;
    logic [7:0]      executed_command;
    logic            doorbell;
    logic            accepted;
  } result_t;

endpackage

// ----- hdl/pcm_entry_ram.sv -----
`timescale 1ns / 1ps

module pcm_entry_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [pcm_pkg::EntryAw-1:0]  waddr_i,
  input  pcm_pkg::entry_t              wdata_i,
  input  logic                         re_i,
  input  logic [pcm_pkg::EntryAw-1:0]  raddr_i,
  output pcm_pkg::entry_t              rdata_o
);

  pcm_pkg::entry_t mem_q [pcm_pkg::Entries];
  pcm_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/per_cpu_command_mailbox.sv -----
`timescale 1ns / 1ps
// Enqueue: ST_LOOKUP registers the result once the output is free; input waits for ST_IDLE.
// Drain of n pending entries: ST_LOOKUP starts the entry RAM read, ST_DRAIN then gives one
// result per cycle while the output is free; an empty drain answers from ST_LOOKUP.
// Per-core pointers and counters sit in a 16-entry state RAM, one read per item.
// Reset (rst_ni low, async) clears control and the per-core valid bits; no clearing pass.

`include "assert_macros.svh"

module per_cpu_command_mailbox (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // [3:0] core, [11:4] command, [75:12] argument, [79:76] zero
  input  logic [79:0]   s_axis_tdata_i,
  // [0] kind
  input  logic [0:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [0] accepted, [1] doorbell, [9:2] executed_command, [10] invalidate_valid,
  // [74:11] invalidate_address, [106:75] work_count, [138:107] shootdown_count,
  // [142:139] pending, [143] zero
  output logic [143:0]  m_axis_tdata_o,
  output logic          m_axis_tlast_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_DRAIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic                            kind_q;
  logic [pcm_pkg::CoreW-1:0]       core_q;
  logic [7:0]                      cmd_q;
  logic [63:0]                     arg_q;

  pcm_pkg::core_state_t            cs_mem_q [pcm_pkg::Cores];
  logic [pcm_pkg::Cores-1:0]       cs_vld_q;
  pcm_pkg::core_state_t            cs_rd_q;
  logic                            cs_rd_vld_q;
  logic                            cs_we;
  pcm_pkg::core_state_t            cs_wdata;

  pcm_pkg::core_state_t            wk_q, wk_d;

  logic                            ent_we;
  logic [pcm_pkg::EntryAw-1:0]     ent_waddr;
  pcm_pkg::entry_t                 ent_wdata;
  logic                            ent_re;
  logic [pcm_pkg::EntryAw-1:0]     ent_raddr;
  pcm_pkg::entry_t                 ent_rdata;

  logic                            m_valid_q, m_valid_d;
  pcm_pkg::result_t                m_data_q, m_data_d;
  logic                            m_last_q, m_last_d;

  logic                            s_fire;
  logic                            out_free;
  logic                            emit;

  pcm_pkg::core_state_t            cur;
  logic [pcm_pkg::PtrW-1:0]        fill;
  logic                            room;
  logic                            is_inv;
  logic [pcm_pkg::PtrW-1:0]        done_nx;
  logic [pcm_pkg::PtrW-1:0]        rest;

  logic [pcm_pkg::PtrW-1:0]        wk_fill;
  logic                            drain_fill_bad;
  logic                            out_inv_bad;
  logic                            out_bell_bad;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign cur     = cs_rd_vld_q ? cs_rd_q : '0;
  assign fill    = cur.tail - cur.done;
  assign room    = fill < pcm_pkg::PtrW'(pcm_pkg::RingDepth);
  assign is_inv  = (ent_rdata.cmd == pcm_pkg::CmdInvalidate) && (ent_rdata.arg != 64'd0);
  assign done_nx = wk_q.done + pcm_pkg::PtrW'(1);
  assign rest    = wk_q.tail - done_nx;

  always_comb begin
    state_d   = state_q;
    wk_d      = wk_q;
    cs_we     = 1'b0;
    cs_wdata  = cur;
    ent_we    = 1'b0;
    ent_waddr = {core_q, cur.tail[pcm_pkg::SlotW-1:0]};
    ent_wdata = '{cmd: cmd_q, arg: arg_q};
    ent_re    = 1'b0;
    ent_raddr = {core_q, cur.done[pcm_pkg::SlotW-1:0]};
    emit      = 1'b0;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          m_data_d          = '0;
          m_data_d.work_count      = cur.wc;
          m_data_d.shootdown_count = cur.sc;
          m_last_d          = 1'b1;
          if (!kind_q) begin
            emit                = 1'b1;
            m_data_d.accepted   = room;
            m_data_d.doorbell   = room;
            m_data_d.pending    = pcm_pkg::PendW'(room ? fill + pcm_pkg::PtrW'(1) : fill);
            ent_we              = room;
            cs_we               = room;
            cs_wdata.tail       = cur.tail + pcm_pkg::PtrW'(1);
            state_d             = ST_IDLE;
          end else if (fill == '0) begin
            emit              = 1'b1;
            m_data_d.accepted = 1'b1;
            state_d           = ST_IDLE;
          end else begin
            ent_re  = 1'b1;
            wk_d    = cur;
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit    = 1'b1;
          wk_d.done = done_nx;
          if (ent_rdata.cmd == pcm_pkg::CmdCounted) begin
            wk_d.wc = wk_q.wc + 32'd1;
          end
          if (is_inv) begin
            wk_d.sc = wk_q.sc + 32'd1;
          end
          m_data_d                    = '0;
          m_data_d.accepted           = 1'b1;
          m_data_d.executed_command   = ent_rdata.cmd;
          m_data_d.invalidate_valid   = is_inv;
          m_data_d.invalidate_address = is_inv ? ent_rdata.arg : 64'd0;
          m_data_d.work_count         = wk_d.wc;
          m_data_d.shootdown_count    = wk_d.sc;
          m_data_d.pending            = pcm_pkg::PendW'(rest);
          m_last_d                    = (rest == '0);
          ent_raddr = {core_q, done_nx[pcm_pkg::SlotW-1:0]};
          if (rest == '0) begin
            cs_we    = 1'b1;
            cs_wdata = wk_d;
            state_d  = ST_IDLE;
          end else begin
            ent_re = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (emit) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      cs_vld_q  <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cs_we) begin
        cs_vld_q[core_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      kind_q      <= s_axis_tuser_i[0];
      core_q      <= s_axis_tdata_i[pcm_pkg::CoreW-1:0];
      cmd_q       <= s_axis_tdata_i[11:4];
      arg_q       <= s_axis_tdata_i[75:12];
      cs_rd_q     <= cs_mem_q[s_axis_tdata_i[pcm_pkg::CoreW-1:0]];
      cs_rd_vld_q <= cs_vld_q[s_axis_tdata_i[pcm_pkg::CoreW-1:0]];
    end
    if (cs_we) begin
      cs_mem_q[core_q] <= cs_wdata;
    end
    wk_q     <= wk_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  pcm_entry_ram u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  assign wk_fill        = wk_q.tail - wk_q.done;
  assign drain_fill_bad = (state_q == ST_DRAIN) &&
                          (wk_fill == '0 || wk_fill > pcm_pkg::PtrW'(pcm_pkg::RingDepth));
  assign out_inv_bad    = m_valid_q && m_data_q.invalidate_valid &&
                          (m_data_q.executed_command != pcm_pkg::CmdInvalidate);
  assign out_bell_bad   = m_valid_q && m_data_q.doorbell && !m_data_q.accepted;

  `ASSERT_AT(a_accept_to_lookup, s_fire |=> state_q == ST_LOOKUP, "transfer not followed by lookup")
  `ASSERT_NEVER(a_drain_fill, drain_fill_bad, "drain ring fill out of range")
  `ASSERT_NEVER(a_inv_cmd, out_inv_bad, "invalidate without invalidate command")
  `ASSERT_NEVER(a_bell_acc, out_bell_bad, "doorbell on refused enqueue")

endmodule

// ----- test/pcm_checker.sv -----
`timescale 1ns / 1ps

package pcm_tb_pkg;

  typedef enum logic [0:0] {
    KindEnqueue = 1'b0,
    KindDrain   = 1'b1
  } item_kind_e;

endpackage

module pcm_checker
  import pcm_pkg::*;
  import pcm_tb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [79:0]  in_data_i,
  input  logic [0:0]   in_kind_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [143:0] out_data_i,
  input  logic         out_last_i,
  output int           errors_o,
  output int           waiting_o,
  output int           results_o,
  output int           invalidates_o,
  output int           refusals_o
);

  localparam int unsigned PtrSpan = 2 * RingDepth;

  typedef struct {
    result_t fields;
    logic    last;
  } mail_result_t;

  mail_result_t expected_results[$];

  logic [7:0]  ring_cmd   [Cores][RingDepth];
  logic [63:0] ring_arg   [Cores][RingDepth];
  int unsigned tail_ptr   [Cores];
  int unsigned done_ptr   [Cores];
  logic [31:0] work_total [Cores];
  logic [31:0] shoot_total[Cores];

  initial begin
    errors_o      = 0;
    waiting_o     = 0;
    results_o     = 0;
    invalidates_o = 0;
    refusals_o    = 0;
    for (int c = 0; c < Cores; c++) begin
      tail_ptr[c]    = 0;
      done_ptr[c]    = 0;
      work_total[c]  = '0;
      shoot_total[c] = '0;
      for (int s = 0; s < RingDepth; s++) begin
        ring_cmd[c][s] = '0;
        ring_arg[c][s] = '0;
      end
    end
  end

  function automatic int unsigned fill_level(int unsigned core);
    return (tail_ptr[core] + PtrSpan - done_ptr[core]) % PtrSpan;
  endfunction

  function automatic void predict_mailbox(item_kind_e kind, int unsigned core,
                                          logic [7:0] cmd, logic [63:0] arg);
    mail_result_t r;
    int unsigned  level;
    int unsigned  slot;
    logic [7:0]   ec;
    logic [63:0]  ea;
    r.fields = '0;
    r.last   = 1'b1;
    level    = fill_level(core);
    if (kind == KindEnqueue) begin
      if (level < RingDepth) begin
        slot                 = tail_ptr[core] % RingDepth;
        ring_cmd[core][slot] = cmd;
        ring_arg[core][slot] = arg;
        tail_ptr[core]       = (tail_ptr[core] + 1) % PtrSpan;
        level++;
        r.fields.accepted = 1'b1;
        r.fields.doorbell = 1'b1;
      end else begin
        refusals_o++;
      end
      r.fields.work_count      = work_total[core];
      r.fields.shootdown_count = shoot_total[core];
      r.fields.pending         = PendW'(level);
      expected_results.push_back(r);
    end else if (level == 0) begin
      r.fields.accepted        = 1'b1;
      r.fields.work_count      = work_total[core];
      r.fields.shootdown_count = shoot_total[core];
      expected_results.push_back(r);
    end else begin
      while (fill_level(core) != 0) begin
        slot = done_ptr[core] % RingDepth;
        ec   = ring_cmd[core][slot];
        ea   = ring_arg[core][slot];
        r.fields = '0;
        r.fields.accepted         = 1'b1;
        r.fields.executed_command = ec;
        if (ec == CmdCounted) work_total[core] = work_total[core] + 32'd1;
        if (ec == CmdInvalidate && ea != '0) begin
          r.fields.invalidate_valid   = 1'b1;
          r.fields.invalidate_address = ea;
          shoot_total[core]           = shoot_total[core] + 32'd1;
        end
        ring_cmd[core][slot] = '0;
        ring_arg[core][slot] = '0;
        done_ptr[core]       = (done_ptr[core] + 1) % PtrSpan;
        level                = fill_level(core);
        r.fields.work_count      = work_total[core];
        r.fields.shootdown_count = shoot_total[core];
        r.fields.pending         = PendW'(level);
        r.last                   = (level == 0);
        expected_results.push_back(r);
      end
    end
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors_o++;
      if (errors_o <= 10)
        $display("result %0d %s: expected %h, got %h", results_o, name, want, got);
    end
  endfunction

  function automatic void check_result(result_t got, logic got_last);
    mail_result_t want;
    if (expected_results.size() == 0) begin
      errors_o++;
      if (errors_o <= 10)
        $display("result %0d arrived with nothing expected: %h last %b",
                 results_o, got, got_last);
    end else begin
      want = expected_results.pop_front();
      compare_field("accepted", want.fields.accepted, got.accepted);
      compare_field("doorbell", want.fields.doorbell, got.doorbell);
      compare_field("executed_command", want.fields.executed_command,
                    got.executed_command);
      compare_field("invalidate_valid", want.fields.invalidate_valid,
                    got.invalidate_valid);
      compare_field("invalidate_address", want.fields.invalidate_address,
                    got.invalidate_address);
      compare_field("work_count", want.fields.work_count, got.work_count);
      compare_field("shootdown_count", want.fields.shootdown_count, got.shootdown_count);
      compare_field("pending", want.fields.pending, got.pending);
      compare_field("pad", want.fields.pad, got.pad);
      compare_field("last", want.last, got_last);
      if (got.invalidate_valid === 1'b1) invalidates_o++;
    end
    results_o++;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        predict_mailbox(item_kind_e'(in_kind_i), int'(in_data_i[3:0]),
                        in_data_i[11:4], in_data_i[75:12]);
      if (out_valid_i && out_ready_i)
        check_result(result_t'(out_data_i), out_last_i);
      waiting_o = expected_results.size();
    end
  end

endmodule

// ----- test/tb_per_cpu_command_mailbox.sv -----
`timescale 1ns / 1ps

module tb_per_cpu_command_mailbox;
  import pcm_pkg::*;
  import pcm_tb_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 150;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [79:0]  s_axis_tdata_i;
  logic [0:0]   s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [143:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;

  int          mismatches;
  int          results_waiting;
  int          results_seen;
  int          invalidates_seen;
  int          refused_enqueues;
  int unsigned cycle_count;
  int unsigned items_sent;

  per_cpu_command_mailbox uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  pcm_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_i    (s_axis_tready_o),
    .in_data_i     (s_axis_tdata_i),
    .in_kind_i     (s_axis_tuser_i),
    .out_valid_i   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_data_i    (m_axis_tdata_o),
    .out_last_i    (m_axis_tlast_o),
    .errors_o      (mismatches),
    .waiting_o     (results_waiting),
    .results_o     (results_seen),
    .invalidates_o (invalidates_seen),
    .refusals_o    (refused_enqueues)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer_item(item_kind_e kind, logic [3:0] core, logic [7:0] cmd,
                            logic [63:0] arg, int unsigned gap);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {4'b0, arg, cmd, core};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic offer_random_item(int unsigned gap);
    item_kind_e  kind;
    logic [3:0]  core;
    logic [7:0]  cmd;
    logic [63:0] arg;
    int unsigned sel;
    kind = ($urandom_range(0, 99) < 25) ? KindDrain : KindEnqueue;
    core = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    sel  = $urandom_range(0, 9);
    if (sel < 4) cmd = CmdCounted;
    else if (sel < 7) cmd = CmdInvalidate;
    else cmd = 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 9);
    if (sel == 0) arg = '0;
    else if (sel == 1) arg = '1;
    else arg = {$urandom, $urandom};
    offer_item(kind, core, cmd, arg, gap);
  endtask

  initial begin
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    items_sent      = 0;
    rst_ni          = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one entry of each command flavor on core 0, then drain it
    offer_item(KindEnqueue, 4'd0, CmdCounted, 64'd0, pick_gap());
    offer_item(KindEnqueue, 4'd0, CmdInvalidate, '1, pick_gap());
    offer_item(KindEnqueue, 4'd0, CmdInvalidate, 64'd0, pick_gap());
    offer_item(KindEnqueue, 4'd0, 8'd0, {$urandom, $urandom}, pick_gap());
    offer_item(KindEnqueue, 4'd0, 8'hFF, 64'h8000_0000_0000_0001, pick_gap());
    offer_item(KindDrain, 4'd0, 8'd0, 64'd0, pick_gap());
    // fill core 15 past full, then drain all eight
    for (int i = 0; i < RingDepth + 1; i++)
      offer_item(KindEnqueue, 4'd15, (i % 2 == 0) ? CmdCounted : CmdInvalidate,
                 {$urandom, $urandom}, pick_gap());
    offer_item(KindDrain, 4'd15, 8'hFF, '1, pick_gap());
    offer_item(KindDrain, 4'd15, 8'd0, 64'd0, pick_gap());
    offer_item(KindDrain, 4'd3, 8'd0, 64'd0, pick_gap());

    for (int i = 0; i < RandomItems; i++)
      offer_random_item((i >= 70 && i < 100) ? 0 : pick_gap());
    s_axis_tvalid_i <= 1'b0;

    do @(negedge clk_i); while (results_waiting != 0);
    repeat (20) @(posedge clk_i);

    $display("run: %0d items in, %0d results checked, %0d invalidations, %0d refused enqueues",
             items_sent, results_seen, invalidates_seen, refused_enqueues);
    $display("run: %0d cycles, field mismatches %0d", cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("per_cpu_command_mailbox: match");
    end else begin
      $display("per_cpu_command_mailbox: mismatch");
    end
    $finish;
  end

  initial begin
    bit          rdy;
    bit          held;
    int unsigned stall_left;
    int unsigned steady_left;
    int unsigned r;
    m_axis_tready_i = 1'b0;
    held            = 1'b0;
    stall_left      = 0;
    steady_left     = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      // hold off long enough for the block to back up and stall its input
      if (!held && results_seen >= 40) begin
        held       = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        rdy = 1'b0;
        stall_left--;
      end else if (steady_left > 0) begin
        rdy = 1'b1;
        steady_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          rdy        = 1'b0;
          stall_left = $urandom_range(8, 40);
        end else if (r < 12) begin
          rdy         = 1'b1;
          steady_left = $urandom_range(30, 80);
        end else begin
          rdy = ($urandom_range(0, 3) != 0);
        end
      end
      m_axis_tready_i <= rdy;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("per_cpu_command_mailbox: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pcm_pkg.sv
hdl/pcm_entry_ram.sv
hdl/per_cpu_command_mailbox.sv
test/pcm_checker.sv
test/tb_per_cpu_command_mailbox.sv
